// ===== hw/rtl/biws_pkg.sv =====
// ----------------------------------------------------------------------------
// biws_pkg
// Shared types, constants and helpers for the bouncing image window scroller.
// ----------------------------------------------------------------------------
package biws_pkg;

  localparam int MATRIX_WIDTH  = 32;
  localparam int MATRIX_HEIGHT = 8;
  localparam int IMAGE_DEPTH   = 2048;
  localparam int TICK_DIVISOR  = 5;
  localparam int QUEUE_DEPTH   = 4;

  localparam int ADDR_W      = $clog2(IMAGE_DEPTH);
  localparam int DIM_W       = 8;
  localparam int OFFSET_W    = 8;
  localparam int COLOR_W     = 24;
  localparam int TICK_W      = 32;
  localparam int COLUMN_W    = 5;
  localparam int ROW_W       = 3;
  localparam int LED_W       = 8;
  localparam int SRC_ROW_W   = OFFSET_W + 1;
  localparam int ADDR_CALC_W = SRC_ROW_W + DIM_W + 1;
  localparam int CFG_INDEX_W = 1;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_RENDER = 2'd2
  } biws_kind_t;

  typedef struct packed {
    biws_kind_t           kind;
    logic [ADDR_W-1:0]    pixel_address;
    logic [COLOR_W-1:0]   pixel_color;
    logic [TICK_W-1:0]    tick_value;
    logic [COLUMN_W-1:0]  column;
    logic [ROW_W-1:0]     row;
  } biws_in_t;

  typedef struct packed {
    logic [LED_W-1:0]   led_index;
    logic [COLOR_W-1:0] led_color;
  } biws_out_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } biws_cfg_t;

  // One queued operation: either a pixel write or a classified render.
  typedef struct packed {
    logic                 is_load;
    logic [ADDR_W-1:0]    load_addr;
    logic [COLOR_W-1:0]   load_color;
    logic [SRC_ROW_W-1:0] src_row;
    logic [COLUMN_W-1:0]  column;
    logic [LED_W-1:0]     led_index;
    logic                 black;
  } biws_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } biws_qstat_t;

  // Since 16 is 1 modulo 5, a word is congruent to the sum of its nibbles.
  // The sum is folded twice so that at most 16 remains.
  function automatic logic tick_on_step(input logic [TICK_W-1:0] t);
    logic [6:0] s;
    logic [4:0] f1;
    logic [4:0] f2;
    s = '0;
    for (int i = 0; i < TICK_W / 4; i++) begin
      s = s + 7'(t[4*i +: 4]);
    end
    f1 = 5'(s[6:4]) + 5'(s[3:0]);
    f2 = 5'(f1[4]) + 5'(f1[3:0]);
    return (f2 == 5'(0)) || (f2 == 5'(TICK_DIVISOR)) ||
           (f2 == 5'(2 * TICK_DIVISOR)) || (f2 == 5'(3 * TICK_DIVISOR));
  endfunction

endpackage

// ===== hw/rtl/biws_front.sv =====
// ----------------------------------------------------------------------------
// biws_front
// Accepts items, keeps the scroll state and classifies loads and renders.
// ----------------------------------------------------------------------------
module biws_front (
  input  logic                clk,
  input  logic                rst,
  input  biws_pkg::biws_cfg_t cfg,
  input  logic                in_valid,
  input  logic                in_stall,
  input  biws_pkg::biws_in_t  in_data,
  output logic                push,
  output biws_pkg::biws_op_t  push_op
);

  logic [biws_pkg::OFFSET_W-1:0] scroll_offset;
  logic [biws_pkg::OFFSET_W-1:0] scroll_offset_next;
  logic                          scroll_direction;
  logic                          scroll_direction_next;

  logic                           accept;
  logic                           empty_image;
  logic [biws_pkg::DIM_W-1:0]     max_off;
  logic signed [biws_pkg::OFFSET_W+1:0] pos;
  logic [biws_pkg::SRC_ROW_W-1:0] src_row;
  int                             serp_row;
  logic                           in_matrix;

  assign accept      = in_valid && !in_stall;
  assign empty_image = (cfg.image_width == '0) || (cfg.image_height == '0);

  always_comb begin
    if (cfg.image_height > biws_pkg::DIM_W'(biws_pkg::MATRIX_HEIGHT)) begin
      max_off = cfg.image_height - biws_pkg::DIM_W'(biws_pkg::MATRIX_HEIGHT);
    end else begin
      max_off = '0;
    end
    pos = $signed({2'b00, scroll_offset}) +
          (scroll_direction ? -(biws_pkg::OFFSET_W+2)'(1) : (biws_pkg::OFFSET_W+2)'(1));

    scroll_offset_next    = scroll_offset;
    scroll_direction_next = scroll_direction;
    if (accept && (in_data.kind == biws_pkg::KIND_TICK) && !empty_image &&
        (max_off != '0) && biws_pkg::tick_on_step(in_data.tick_value)) begin
      if (pos >= $signed({2'b00, max_off})) begin
        scroll_offset_next    = max_off;
        scroll_direction_next = 1'b1;
      end else if (pos <= 0) begin
        scroll_offset_next    = '0;
        scroll_direction_next = 1'b0;
      end else begin
        scroll_offset_next = pos[biws_pkg::OFFSET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_offset    <= '0;
      scroll_direction <= 1'b0;
    end else begin
      scroll_offset    <= scroll_offset_next;
      scroll_direction <= scroll_direction_next;
    end
  end

  // Render classification against the scroll state as it stands now.
  always_comb begin
    src_row   = biws_pkg::SRC_ROW_W'(in_data.row) + biws_pkg::SRC_ROW_W'(scroll_offset);
    serp_row  = in_data.column[0] ? (biws_pkg::MATRIX_HEIGHT - 1 - int'(in_data.row))
                                  : int'(in_data.row);
    in_matrix = (int'(in_data.column) < biws_pkg::MATRIX_WIDTH) &&
                (int'(in_data.row) < biws_pkg::MATRIX_HEIGHT);

    push_op.is_load    = (in_data.kind == biws_pkg::KIND_LOAD);
    push_op.load_addr  = in_data.pixel_address;
    push_op.load_color = in_data.pixel_color;
    push_op.src_row    = src_row;
    push_op.column     = in_data.column;
    push_op.led_index  = biws_pkg::LED_W'(int'(in_data.column) * biws_pkg::MATRIX_HEIGHT
                                          + serp_row);
    push_op.black      = empty_image ||
                         (src_row >= biws_pkg::SRC_ROW_W'(cfg.image_height));

    case (in_data.kind)
      biws_pkg::KIND_LOAD:   push = accept &&
                                    (int'(in_data.pixel_address) < biws_pkg::IMAGE_DEPTH);
      biws_pkg::KIND_RENDER: push = accept && in_matrix;
      default:               push = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/biws_queue.sv =====
// ----------------------------------------------------------------------------
// biws_queue
// Short FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module biws_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  biws_pkg::biws_op_t    push_op,
  input  logic                  pop,
  output biws_pkg::biws_op_t    head_op,
  output biws_pkg::biws_qstat_t stat
);

  biws_pkg::biws_op_t            entries [biws_pkg::QUEUE_DEPTH];
  logic [biws_pkg::QPTR_W-1:0]   wr_ptr;
  logic [biws_pkg::QPTR_W-1:0]   rd_ptr;
  logic [biws_pkg::QCNT_W-1:0]   count;
  logic [biws_pkg::QCNT_W-1:0]   count_next;

  assign head_op    = entries[rd_ptr];
  assign stat.full  = (count == biws_pkg::QCNT_W'(biws_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == biws_pkg::QPTR_W'(biws_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == biws_pkg::QPTR_W'(biws_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// ===== hw/rtl/biws_back.sv =====
// ----------------------------------------------------------------------------
// biws_back
// Computes store addresses, owns the image store and holds the result.
// ----------------------------------------------------------------------------
module biws_back (
  input  logic                  clk,
  input  logic                  rst,
  input  biws_pkg::biws_cfg_t   cfg,
  input  biws_pkg::biws_op_t    head_op,
  input  biws_pkg::biws_qstat_t qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output biws_pkg::biws_out_t   out_data
);

  logic [biws_pkg::COLOR_W-1:0] image_store [biws_pkg::IMAGE_DEPTH];

  logic                             advance;
  logic [biws_pkg::ADDR_CALC_W-1:0] addr_full;

  // Stage A: resolved address.
  logic                          a_valid;
  logic                          a_is_load;
  logic [biws_pkg::ADDR_W-1:0]   a_addr;
  logic [biws_pkg::COLOR_W-1:0]  a_color;
  logic [biws_pkg::LED_W-1:0]    a_led_index;
  logic                          a_black;

  // Stage B: result register with read data.
  logic                          b_valid;
  logic [biws_pkg::LED_W-1:0]    b_led_index;
  logic                          b_black;
  logic [biws_pkg::COLOR_W-1:0]  rd_data;

  assign advance = !b_valid || !out_stall;
  assign pop     = advance && !qstat.empty;

  always_comb begin
    addr_full = biws_pkg::ADDR_CALC_W'(head_op.src_row) *
                biws_pkg::ADDR_CALC_W'(cfg.image_width) +
                biws_pkg::ADDR_CALC_W'(head_op.column);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= pop;
      b_valid <= a_valid && !a_is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_is_load   <= head_op.is_load;
      a_led_index <= head_op.led_index;
      a_color     <= head_op.load_color;
      if (head_op.is_load) begin
        a_addr  <= head_op.load_addr;
        a_black <= 1'b0;
      end else begin
        a_addr  <= addr_full[biws_pkg::ADDR_W-1:0];
        a_black <= head_op.black ||
                   (addr_full >= biws_pkg::ADDR_CALC_W'(biws_pkg::IMAGE_DEPTH));
      end
      b_led_index <= a_led_index;
      b_black     <= a_black;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_valid) begin
      if (a_is_load) begin
        image_store[a_addr] <= a_color;
      end else begin
        rd_data <= image_store[a_addr];
      end
    end
  end

  assign out_valid          = b_valid;
  assign out_data.led_index = b_led_index;
  assign out_data.led_color = b_black ? '0 : rd_data;

endmodule

// ===== hw/rtl/bouncing_image_window_scroller.sv =====
// ----------------------------------------------------------------------------
// bouncing_image_window_scroller
// Scrolling window onto a stored RGB image for a column-serpentine LED matrix.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low: pixel loads,
// frame ticks and render requests. A render result passes the queue register,
// the address multiply stage and the registered image store read, and results
// leave one per clock while out_stall is low. Loads and renders pass through
// the same queue in order, so a render always sees every earlier load. The
// image store needs no clearing after reset. When the output is stalled, up
// to four further items are held in the queue before input is stalled.
module bouncing_image_window_scroller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [biws_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [biws_pkg::DIM_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  biws_pkg::biws_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output biws_pkg::biws_out_t               out_data
);

  biws_pkg::biws_cfg_t   cfg;
  biws_pkg::biws_op_t    push_op;
  biws_pkg::biws_op_t    head_op;
  biws_pkg::biws_qstat_t qstat;
  logic                  push;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        biws_pkg::REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        biws_pkg::REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = qstat.full;

  biws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_op  (push_op)
  );

  biws_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (qstat)
  );

  biws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_op   (head_op),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/biws_checker.sv =====
// ----------------------------------------------------------------------------
// biws_checker
// Port-level checks for the bouncing image window scroller.
// ----------------------------------------------------------------------------
module biws_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input biws_pkg::biws_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input biws_pkg::biws_out_t out_data
);

  // Renders accepted but not yet delivered; the block can hold at most six.
  logic [3:0] pending;
  logic       render_in;
  logic       result_out;

  assign render_in  = in_valid && !in_stall && (in_data.kind == biws_pkg::KIND_RENDER);
  assign result_out = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(render_in) - 4'(result_out);
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result without a pending render");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(biws_pkg::QUEUE_DEPTH + 2))
    else $error("more renders in flight than the block can hold");

endmodule

bind bouncing_image_window_scroller biws_checker u_biws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
